// File: hw/rtl/hsv2rgb_pkg.sv
`default_nettype none

package hsv2rgb_pkg;

    // Color and hue formats
    localparam int COLOR_BITS    = 8;
    localparam int HUE_FRAC_BITS = 4;

    localparam int HUE_W  = 9 + HUE_FRAC_BITS;   // hue code width
    localparam int SPAN_W = 6 + HUE_FRAC_BITS;   // holds one 60 degree span
    localparam int PROD_W = 2 * COLOR_BITS;      // brightness * saturation
    localparam int TERM_W = COLOR_BITS + SPAN_W; // chroma * fraction numerator

    localparam int SECTOR_SPAN = 60 << HUE_FRAC_BITS;
    localparam int MAXC        = (1 << COLOR_BITS) - 1;

    // Sector bounds in hue units
    localparam logic [HUE_W-1:0] HUE_60  = HUE_W'(1 * SECTOR_SPAN);
    localparam logic [HUE_W-1:0] HUE_120 = HUE_W'(2 * SECTOR_SPAN);
    localparam logic [HUE_W-1:0] HUE_180 = HUE_W'(3 * SECTOR_SPAN);
    localparam logic [HUE_W-1:0] HUE_240 = HUE_W'(4 * SECTOR_SPAN);
    localparam logic [HUE_W-1:0] HUE_300 = HUE_W'(5 * SECTOR_SPAN);
    localparam logic [HUE_W-1:0] HUE_360 = HUE_W'(6 * SECTOR_SPAN);

    localparam logic [SPAN_W-1:0]     SPAN_FULL   = SPAN_W'(SECTOR_SPAN);
    localparam logic [TERM_W-1:0]     SPAN_HALF   = TERM_W'(SECTOR_SPAN / 2);
    localparam logic [PROD_W-1:0]     MAXC_HALF   = PROD_W'(MAXC / 2);
    localparam logic [COLOR_BITS:0]   MAXC_X1     = (COLOR_BITS+1)'(MAXC);
    localparam logic [COLOR_BITS:0]   MAXC_X2     = (COLOR_BITS+1)'(2 * MAXC);

    // Divide by the span: drop the power of two, then multiply by 1/15
    localparam int DIV_SHIFT   = HUE_FRAC_BITS + 2;
    localparam int Y_W         = TERM_W - DIV_SHIFT;
    localparam int RECIP_SHIFT = COLOR_BITS + 8;
    localparam int RECIP_W     = RECIP_SHIFT - 3;
    localparam logic [RECIP_W-1:0] RECIP15 = RECIP_W'((1 << RECIP_SHIFT) / 15 + 1);

    // Hue sectors of 60 degrees each
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    typedef struct packed {
        logic [HUE_W-1:0]      hue;
        logic [COLOR_BITS-1:0] saturation;
        logic [COLOR_BITS-1:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } t_rgb;

    // Per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

    typedef struct packed {
        logic                  grey;
        t_sector               sector;
        logic [SPAN_W-1:0]     num;
        logic [COLOR_BITS-1:0] val;
        logic [PROD_W-1:0]     prod;
    } t_s1;

    typedef struct packed {
        logic                  grey;
        t_sector               sector;
        logic [SPAN_W-1:0]     num;
        logic [COLOR_BITS-1:0] val;
        logic [COLOR_BITS-1:0] chroma;
    } t_s2;

    typedef struct packed {
        logic                  grey;
        t_sector               sector;
        logic [COLOR_BITS-1:0] low;
        logic [COLOR_BITS-1:0] chroma;
        logic [TERM_W-1:0]     term;
    } t_s3;

    typedef struct packed {
        logic                  grey;
        t_sector               sector;
        logic [COLOR_BITS-1:0] low;
        logic [COLOR_BITS-1:0] chroma;
        logic [COLOR_BITS-1:0] mid;
    } t_s4;

endpackage

`default_nettype wire

// File: hw/rtl/hsv_to_rgb_converter.sv
`default_nettype none

// HSV to RGB pixel converter. Hue is in 1/16 degree (5760 = 360 degrees),
// saturation, brightness and the red/green/blue outputs are 8-bit levels
// with 255 meaning full scale; all divisions round half up. A hue of 360
// degrees or more gives grey at the level brightness - chroma. The design
// is a five-stage pipeline (sector and product, chroma divide, ramp
// product, ramp divide, channel select into the output register): it takes
// one pixel per clock while the output side does not stall, and each result
// is registered through the stages in order before it is presented.
// Each stage holds its data under back-pressure and fills bubbles, so a
// stall loses nothing.
module hsv_to_rgb_converter (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire hsv2rgb_pkg::t_hsv i_pixel,
    output logic                   o_valid,
    input  wire                    i_ready,
    output hsv2rgb_pkg::t_rgb      o_pixel
);

    hsv2rgb_pkg::t_stage_en en;
    hsv2rgb_pkg::t_s2       s2;
    hsv2rgb_pkg::t_s4       s4;
    hsv2rgb_pkg::t_rgb      n_out;
    hsv2rgb_pkg::t_rgb      r_out;
    logic [4:0]             r_vld;
    logic [hsv2rgb_pkg::COLOR_BITS-1:0] hi;
    logic [hsv2rgb_pkg::COLOR_BITS-1:0] mid;
    logic [hsv2rgb_pkg::COLOR_BITS-1:0] low;

    // A stage loads when it is empty or its contents move on
    always_comb begin
        en.s5 = !r_vld[4] || i_ready;
        en.s4 = !r_vld[3] || en.s5;
        en.s3 = !r_vld[2] || en.s4;
        en.s2 = !r_vld[1] || en.s3;
        en.s1 = !r_vld[0] || en.s2;
    end

    assign o_ready = en.s1;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en.s1) begin
                r_vld[0] <= i_valid;
            end
            if (en.s2) begin
                r_vld[1] <= r_vld[0];
            end
            if (en.s3) begin
                r_vld[2] <= r_vld[1];
            end
            if (en.s4) begin
                r_vld[3] <= r_vld[2];
            end
            if (en.s5) begin
                r_vld[4] <= r_vld[3];
            end
        end
    end

    hsv2rgb_front u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_pixel (i_pixel),
        .o_s2    (s2)
    );

    hsv2rgb_mid u_mid (
        .i_clk (i_clk),
        .i_en  (en),
        .i_s2  (s2),
        .o_s4  (s4)
    );

    // Stage 5: offset by minimum level and route to channels by sector; grey gives the minimum on all channels
    always_comb begin
        low = s4.low;
        hi  = s4.chroma + s4.low;
        mid = s4.mid + s4.low;
        if (s4.grey) begin
            n_out = '{red: low, green: low, blue: low};
        end else begin
            case (s4.sector)
                hsv2rgb_pkg::SEC_R_TO_Y: n_out = '{red: hi,  green: mid, blue: low};
                hsv2rgb_pkg::SEC_Y_TO_G: n_out = '{red: mid, green: hi,  blue: low};
                hsv2rgb_pkg::SEC_G_TO_C: n_out = '{red: low, green: hi,  blue: mid};
                hsv2rgb_pkg::SEC_C_TO_B: n_out = '{red: low, green: mid, blue: hi};
                hsv2rgb_pkg::SEC_B_TO_M: n_out = '{red: mid, green: low, blue: hi};
                default:                 n_out = '{red: hi,  green: low, blue: mid};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s5) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld[4];
    assign o_pixel = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/hsv2rgb_front.sv
`default_nettype none

// Stages 1 and 2: hue sector and fraction, chroma = brightness * saturation / MAXC
module hsv2rgb_front (
    input  wire                        i_clk,
    input  wire hsv2rgb_pkg::t_stage_en i_en,
    input  wire hsv2rgb_pkg::t_hsv      i_pixel,
    output hsv2rgb_pkg::t_s2            o_s2
);

    hsv2rgb_pkg::t_s1     n_s1;
    hsv2rgb_pkg::t_s1     r_s1;
    hsv2rgb_pkg::t_s2     n_s2;
    hsv2rgb_pkg::t_s2     r_s2;
    logic [hsv2rgb_pkg::HUE_W-1:0]      base;
    logic [hsv2rgb_pkg::SPAN_W-1:0]     offset;
    logic                               odd;
    logic [hsv2rgb_pkg::COLOR_BITS-1:0] q0;
    logic [hsv2rgb_pkg::COLOR_BITS:0]   rem;
    logic [hsv2rgb_pkg::COLOR_BITS:0]   quot;

    // Stage 1: sector search over fixed bounds, product with rounding bias
    always_comb begin
        if (i_pixel.hue >= hsv2rgb_pkg::HUE_300) begin
            n_s1.sector = hsv2rgb_pkg::SEC_M_TO_R;
            base        = hsv2rgb_pkg::HUE_300;
        end else if (i_pixel.hue >= hsv2rgb_pkg::HUE_240) begin
            n_s1.sector = hsv2rgb_pkg::SEC_B_TO_M;
            base        = hsv2rgb_pkg::HUE_240;
        end else if (i_pixel.hue >= hsv2rgb_pkg::HUE_180) begin
            n_s1.sector = hsv2rgb_pkg::SEC_C_TO_B;
            base        = hsv2rgb_pkg::HUE_180;
        end else if (i_pixel.hue >= hsv2rgb_pkg::HUE_120) begin
            n_s1.sector = hsv2rgb_pkg::SEC_G_TO_C;
            base        = hsv2rgb_pkg::HUE_120;
        end else if (i_pixel.hue >= hsv2rgb_pkg::HUE_60) begin
            n_s1.sector = hsv2rgb_pkg::SEC_Y_TO_G;
            base        = hsv2rgb_pkg::HUE_60;
        end else begin
            n_s1.sector = hsv2rgb_pkg::SEC_R_TO_Y;
            base        = '0;
        end
        odd = (n_s1.sector == hsv2rgb_pkg::SEC_Y_TO_G) ||
              (n_s1.sector == hsv2rgb_pkg::SEC_C_TO_B) ||
              (n_s1.sector == hsv2rgb_pkg::SEC_M_TO_R);
        offset    = hsv2rgb_pkg::SPAN_W'(i_pixel.hue - base);
        // falling ramp in odd sectors
        n_s1.num  = odd ? (hsv2rgb_pkg::SPAN_FULL - offset) : offset;
        n_s1.grey = (i_pixel.hue >= hsv2rgb_pkg::HUE_360);
        n_s1.val  = i_pixel.brightness;
        n_s1.prod = hsv2rgb_pkg::PROD_W'(i_pixel.brightness)
                  * hsv2rgb_pkg::PROD_W'(i_pixel.saturation)
                  + hsv2rgb_pkg::MAXC_HALF;
    end

    // Stage 2: divide by 2^N-1: x/2^N + correction, remainder below 2*MAXC+1
    always_comb begin
        q0   = r_s1.prod[hsv2rgb_pkg::PROD_W-1:hsv2rgb_pkg::COLOR_BITS];
        rem  = {1'b0, r_s1.prod[hsv2rgb_pkg::COLOR_BITS-1:0]} + {1'b0, q0};
        if (rem >= hsv2rgb_pkg::MAXC_X2) begin
            quot = {1'b0, q0} + (hsv2rgb_pkg::COLOR_BITS+1)'(2);
        end else if (rem >= hsv2rgb_pkg::MAXC_X1) begin
            quot = {1'b0, q0} + (hsv2rgb_pkg::COLOR_BITS+1)'(1);
        end else begin
            quot = {1'b0, q0};
        end
        n_s2.grey   = r_s1.grey;
        n_s2.sector = r_s1.sector;
        n_s2.num    = r_s1.num;
        n_s2.val    = r_s1.val;
        n_s2.chroma = quot[hsv2rgb_pkg::COLOR_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1 <= n_s1;
        end
        if (i_en.s2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

`default_nettype wire

// File: hw/rtl/hsv2rgb_mid.sv
`default_nettype none

// Stages 3 and 4: minimum level and intermediate ramp = chroma * num / span
module hsv2rgb_mid (
    input  wire                        i_clk,
    input  wire hsv2rgb_pkg::t_stage_en i_en,
    input  wire hsv2rgb_pkg::t_s2       i_s2,
    output hsv2rgb_pkg::t_s4            o_s4
);

    hsv2rgb_pkg::t_s3 n_s3;
    hsv2rgb_pkg::t_s3 r_s3;
    hsv2rgb_pkg::t_s4 n_s4;
    hsv2rgb_pkg::t_s4 r_s4;
    logic [hsv2rgb_pkg::Y_W-1:0]                       y;
    logic [hsv2rgb_pkg::Y_W+hsv2rgb_pkg::RECIP_W-1:0]  recip_prod;

    // Stage 3: product with half-span rounding bias
    always_comb begin
        n_s3.grey   = i_s2.grey;
        n_s3.sector = i_s2.sector;
        n_s3.low    = i_s2.val - i_s2.chroma;
        n_s3.chroma = i_s2.chroma;
        n_s3.term   = hsv2rgb_pkg::TERM_W'(i_s2.chroma) * hsv2rgb_pkg::TERM_W'(i_s2.num)
                    + hsv2rgb_pkg::SPAN_HALF;
    end

    // Stage 4: span = 15 * 2^k, shift then reciprocal multiply (exact here)
    always_comb begin
        y           = r_s3.term[hsv2rgb_pkg::TERM_W-1:hsv2rgb_pkg::DIV_SHIFT];
        recip_prod  = (hsv2rgb_pkg::Y_W+hsv2rgb_pkg::RECIP_W)'(y)
                    * (hsv2rgb_pkg::Y_W+hsv2rgb_pkg::RECIP_W)'(hsv2rgb_pkg::RECIP15);
        n_s4.grey   = r_s3.grey;
        n_s4.sector = r_s3.sector;
        n_s4.low    = r_s3.low;
        n_s4.chroma = r_s3.chroma;
        n_s4.mid    = recip_prod[hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::COLOR_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3 <= n_s3;
        end
        if (i_en.s4) begin
            r_s4 <= n_s4;
        end
    end

    assign o_s4 = r_s4;

endmodule

`default_nettype wire

// File: bench/hsv_to_rgb_checker.sv
`default_nettype none

// Watches both pixel channels, predicts each RGB result from the accepted
// HSV pixel and compares results in order, one channel level at a time.
module hsv_to_rgb_checker (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire                    i_in_ready,
    input  wire hsv2rgb_pkg::t_hsv i_in_pixel,
    input  wire                    i_out_valid,
    input  wire                    i_out_ready,
    input  wire hsv2rgb_pkg::t_rgb i_out_pixel,
    output int                     o_mismatch_count,
    output int                     o_pending_count
);

    hsv2rgb_pkg::t_rgb expected_rgb_q[$];

    // Fixed-point HSV to RGB; all divisions round half up
    function automatic hsv2rgb_pkg::t_rgb convert_hsv(input hsv2rgb_pkg::t_hsv px);
        logic [hsv2rgb_pkg::PROD_W-1:0]     prod;
        logic [hsv2rgb_pkg::COLOR_BITS-1:0] chroma;
        logic [hsv2rgb_pkg::COLOR_BITS-1:0] low;
        logic [hsv2rgb_pkg::COLOR_BITS-1:0] hi;
        logic [hsv2rgb_pkg::COLOR_BITS-1:0] mid;
        logic [2:0]                         sec_idx;
        logic [hsv2rgb_pkg::SPAN_W-1:0]     offset;
        logic [hsv2rgb_pkg::SPAN_W-1:0]     num;
        logic [hsv2rgb_pkg::TERM_W-1:0]     ramp;
        hsv2rgb_pkg::t_sector               sector;
        hsv2rgb_pkg::t_rgb                  rgb;
        prod   = hsv2rgb_pkg::PROD_W'(px.saturation) * hsv2rgb_pkg::PROD_W'(px.brightness);
        chroma = hsv2rgb_pkg::COLOR_BITS'((prod + hsv2rgb_pkg::MAXC / 2) / hsv2rgb_pkg::MAXC);
        low    = px.brightness - chroma;
        // full circle and out-of-range codes: grey at the minimum level
        if (px.hue >= hsv2rgb_pkg::HUE_360) begin
            rgb = '{low, low, low};
            return rgb;
        end
        sec_idx = 3'(px.hue / hsv2rgb_pkg::SECTOR_SPAN);
        sector  = hsv2rgb_pkg::t_sector'(sec_idx);
        offset  = hsv2rgb_pkg::SPAN_W'(px.hue - sec_idx * hsv2rgb_pkg::SECTOR_SPAN);
        // ramp rises in even sectors, falls in odd ones
        num     = sec_idx[0] ? hsv2rgb_pkg::SPAN_FULL - offset : offset;
        ramp    = hsv2rgb_pkg::TERM_W'(chroma) * hsv2rgb_pkg::TERM_W'(num);
        mid     = hsv2rgb_pkg::COLOR_BITS'((ramp + hsv2rgb_pkg::SECTOR_SPAN / 2)
                                           / hsv2rgb_pkg::SECTOR_SPAN) + low;
        hi      = chroma + low;
        case (sector)
            hsv2rgb_pkg::SEC_R_TO_Y: rgb = '{hi, mid, low};
            hsv2rgb_pkg::SEC_Y_TO_G: rgb = '{mid, hi, low};
            hsv2rgb_pkg::SEC_G_TO_C: rgb = '{low, hi, mid};
            hsv2rgb_pkg::SEC_C_TO_B: rgb = '{low, mid, hi};
            hsv2rgb_pkg::SEC_B_TO_M: rgb = '{mid, low, hi};
            default:                 rgb = '{hi, low, mid};
        endcase
        return rgb;
    endfunction

    task automatic check_level(input string channel,
                               input logic [hsv2rgb_pkg::COLOR_BITS-1:0] want,
                               input logic [hsv2rgb_pkg::COLOR_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, channel, want, got);
            o_mismatch_count++;
        end
    endtask

    // Score transfers on both channels
    always @(posedge i_clk) begin : score
        hsv2rgb_pkg::t_rgb want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_rgb_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time,
                             i_out_pixel);
                    o_mismatch_count++;
                end else begin
                    want = expected_rgb_q.pop_front();
                    check_level("red", want.red, i_out_pixel.red);
                    check_level("green", want.green, i_out_pixel.green);
                    check_level("blue", want.blue, i_out_pixel.blue);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_rgb_q.push_back(convert_hsv(i_in_pixel));
            o_pending_count = expected_rgb_q.size();
        end
    end

endmodule

`default_nettype wire

// File: bench/tb_hsv_to_rgb_converter.sv
`default_nettype none

module tb_hsv_to_rgb_converter;

    localparam int DRAIN_CYCLES = 12;   // five pipeline stages plus margin
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 210;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    hsv2rgb_pkg::t_hsv in_pixel  = '0;
    logic              out_ready = 1'b0;

    logic              dut_in_ready;
    logic              dut_out_valid;
    hsv2rgb_pkg::t_rgb dut_out_pixel;

    bit send_gaps   = 1'b0;
    bit take_gaps   = 1'b0;
    bit hold_output = 1'b0;
    int mismatch_count;
    int pending_count;

    always #5 clk = ~clk;

    hsv_to_rgb_converter u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (dut_in_ready),
        .i_pixel (in_pixel),
        .o_valid (dut_out_valid),
        .i_ready (out_ready),
        .o_pixel (dut_out_pixel)
    );

    hsv_to_rgb_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (dut_in_ready),
        .i_in_pixel       (in_pixel),
        .i_out_valid      (dut_out_valid),
        .i_out_ready      (out_ready),
        .i_out_pixel      (dut_out_pixel),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    // Offer one pixel, after an optional gap; valid is left high on return
    task automatic send_pixel(input hsv2rgb_pkg::t_hsv px);
        int gap;
        gap = send_gaps ? $urandom_range(19, 0) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_pixel <= px;
        do begin
            @(posedge clk);
        end while (!dut_in_ready);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Hue mostly in range, some near sector bounds, some at or past 360
    function automatic hsv2rgb_pkg::t_hsv random_pixel();
        hsv2rgb_pkg::t_hsv px;
        int                pick;
        pick = $urandom_range(99, 0);
        if (pick < 70)
            px.hue = hsv2rgb_pkg::HUE_W'($urandom_range(5759, 0));
        else if (pick < 88)
            px.hue = hsv2rgb_pkg::HUE_W'($urandom_range(6, 0) * hsv2rgb_pkg::SECTOR_SPAN
                                         + $urandom_range(4, 0) - 2);
        else
            px.hue = hsv2rgb_pkg::HUE_W'($urandom_range(8191, 5760));
        pick = $urandom_range(9, 0);
        px.saturation = (pick == 0) ? '0 : (pick == 1) ? '1 :
                        hsv2rgb_pkg::COLOR_BITS'($urandom());
        pick = $urandom_range(9, 0);
        px.brightness = (pick == 0) ? '0 : (pick == 1) ? '1 :
                        hsv2rgb_pkg::COLOR_BITS'($urandom());
        return px;
    endfunction

    // Result side: random stalls, plus one long hold on request
    initial begin : receiver
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        forever begin
            if (hold_output && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            stall = take_gaps ? $urandom_range(19, 0) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do begin
                @(posedge clk);
            end while (!dut_out_valid);
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners: sector bounds and midpoints, full circle, out-of-range hue,
        // zero and full saturation/brightness, rounding at half levels
        send_gaps = 1'b1;
        take_gaps = 1'b1;
        send_pixel('{13'd0,    8'd255, 8'd255});
        send_pixel('{13'd0,    8'd0,   8'd0});
        send_pixel('{13'd480,  8'd255, 8'd255});
        send_pixel('{13'd959,  8'd255, 8'd255});
        send_pixel('{13'd960,  8'd255, 8'd255});
        send_pixel('{13'd1440, 8'd255, 8'd255});
        send_pixel('{13'd1920, 8'd255, 8'd255});
        send_pixel('{13'd2400, 8'd200, 8'd100});
        send_pixel('{13'd2880, 8'd255, 8'd255});
        send_pixel('{13'd3360, 8'd128, 8'd77});
        send_pixel('{13'd3840, 8'd255, 8'd255});
        send_pixel('{13'd4320, 8'd1,   8'd255});
        send_pixel('{13'd4800, 8'd255, 8'd255});
        send_pixel('{13'd5280, 8'd255, 8'd1});
        send_pixel('{13'd5759, 8'd255, 8'd255});
        send_pixel('{13'd5760, 8'd255, 8'd255});
        send_pixel('{13'd5761, 8'd100, 8'd200});
        send_pixel('{13'd8191, 8'd255, 8'd255});
        send_pixel('{13'd6000, 8'd0,   8'd255});
        send_pixel('{13'd480,  8'd128, 8'd128});
        send_pixel('{13'd1000, 8'd255, 8'd0});
        drain_results();

        // random phases, with input and output gaps switched on per phase
        for (int phase = 0; phase < 5; phase++) begin
            send_gaps = (phase == 0 || phase == 2 || phase == 4);
            take_gaps = (phase == 0 || phase == 3 || phase == 4);
            repeat (PHASE_ITEMS) send_pixel(random_pixel());
            drain_results();

            // long output hold while input keeps coming: pipeline fills and stalls
            if (phase == 1) begin
                hold_output = 1'b1;
                repeat (40) send_pixel(random_pixel());
                drain_results();
            end
        end

        if (mismatch_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_front.sv
hw/rtl/hsv2rgb_mid.sv
hw/rtl/hsv_to_rgb_converter.sv
bench/hsv_to_rgb_checker.sv
bench/tb_hsv_to_rgb_converter.sv
